@@ rtl/tce_pkg.sv @@
`default_nettype none

package tce_pkg;

    localparam int ROWS_DEF = 25;
    localparam int COLS_DEF = 80;

    localparam logic [7:0] DEFAULT_COLOR = 8'h0F;
    localparam logic [7:0] CH_NEWLINE    = 8'd10;
    localparam logic [7:0] CH_BACKSPACE  = 8'd8;
    localparam logic [7:0] CH_SPACE      = 8'd32;

    typedef enum logic [2:0] {
        CMD_PUT_CHAR  = 3'd0,
        CMD_SET_CUR   = 3'd1,
        CMD_CLEAR     = 3'd2,
        CMD_SET_COLOR = 3'd3,
        CMD_RST_COLOR = 3'd4,
        CMD_INIT      = 3'd5,
        CMD_READ_CELL = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [7:0]  cell_char;
        logic [7:0]  cell_color;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/text_console_engine.sv @@
// Text console engine: keeps a ROWS x COLS screen of 16-bit cells (character in the low byte,
// colour in the high byte) in one synchronous memory, plus a cursor and a current colour.
// Each command transaction yields one result with the cursor position and, for read cell, the
// cell contents. Each command is accepted in idle and pushes its result from the response state;
// read cell passes through a read state first. Clear and init blank the screen, and a put char
// that runs past the last row scrolls: the memory has one write port, so scroll copies and
// blanking move one cell per cycle. After reset the screen memory is swept to spaces in colour
// 0x0F, during which s_ready stays low. A finished result waits in the output register while
// the next command is taken.
`default_nettype none

module text_console_engine #(
    parameter int ROWS = tce_pkg::ROWS_DEF,
    parameter int COLS = tce_pkg::COLS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_cmd,
    input  wire logic [7:0]         s_ch,
    input  wire logic signed [15:0] s_row_req,
    input  wire logic signed [15:0] s_col_req,
    input  wire logic [3:0]         s_fg,
    input  wire logic [3:0]         s_bg,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [10:0]             m_cursor_pos,
    output logic [4:0]              m_cursor_row,
    output logic [6:0]              m_cursor_col,
    output logic [7:0]              m_cell_char,
    output logic [7:0]              m_cell_color
);

    localparam int NCELLS = ROWS * COLS;
    localparam int AW     = $clog2(NCELLS);

    logic            out_free;
    logic            res_push;
    tce_pkg::res_t   res;
    tce_pkg::res_t   res_reg;
    logic            m_valid_reg, m_valid_next;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [15:0]     ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [15:0]     ram_rdata;

    tce_ctrl #(
        .ROWS   (ROWS),
        .COLS   (COLS),
        .NCELLS (NCELLS),
        .AW     (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .s_ch      (s_ch),
        .s_row_req (s_row_req),
        .s_col_req (s_col_req),
        .s_fg      (s_fg),
        .s_bg      (s_bg),
        .out_free  (out_free),
        .res_push  (res_push),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    tce_ram #(
        .DEPTH (NCELLS),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output register, refilled in the cycle it is taken
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_push) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_push) begin
            res_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cursor_pos = res_reg.cursor_pos;
    assign m_cursor_row = res_reg.cursor_row;
    assign m_cursor_col = res_reg.cursor_col;
    assign m_cell_char  = res_reg.cell_char;
    assign m_cell_color = res_reg.cell_color;

endmodule

`default_nettype wire

@@ rtl/tce_ram.sv @@
`default_nettype none

module tce_ram #(
    parameter int DEPTH = tce_pkg::ROWS_DEF * tce_pkg::COLS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [15:0]   wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [15:0]   rdata
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/tce_ctrl.sv @@
`default_nettype none

module tce_ctrl #(
    parameter int ROWS = tce_pkg::ROWS_DEF,
    parameter int COLS = tce_pkg::COLS_DEF,
    parameter int NCELLS = ROWS * COLS,
    parameter int AW = $clog2(NCELLS)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [2:0]          s_cmd,
    input  wire logic [7:0]          s_ch,
    input  wire logic signed [15:0]  s_row_req,
    input  wire logic signed [15:0]  s_col_req,
    input  wire logic [3:0]          s_fg,
    input  wire logic [3:0]          s_bg,
    input  wire logic                out_free,
    output logic                     res_push,
    output tce_pkg::res_t            res,
    output logic                     ram_we,
    output logic [AW-1:0]            ram_waddr,
    output logic [15:0]              ram_wdata,
    output logic [AW-1:0]            ram_raddr,
    input  wire logic [15:0]         ram_rdata
);

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW = $clog2(COLS);
    localparam logic [AW-1:0] LAST_ADDR   = AW'(NCELLS - 1);
    localparam logic [AW-1:0] BOTTOM_ADDR = AW'((ROWS - 1) * COLS);
    localparam logic [AW-1:0] FIRST_SRC   = AW'((ROWS > 1) ? COLS : 0);

    tce_pkg::state_t state_reg, state_next;
    logic [RW-1:0] cur_row_reg, cur_row_next;
    logic [CW-1:0] cur_col_reg, cur_col_next;
    logic [7:0]    color_reg, color_next;
    logic [7:0]    fill_color_reg, fill_color_next;
    logic [AW-1:0] scan_reg, scan_next;
    logic [AW-1:0] fill_reg, fill_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic [7:0]    cell_char_reg, cell_char_next;
    logic [7:0]    cell_color_reg, cell_color_next;

    logic          accept;
    logic [RW-1:0] clamp_row;
    logic [CW-1:0] clamp_col;
    logic [RW:0]   row_inc;
    logic [CW:0]   col_inc;
    logic [RW-1:0] a_row;
    logic [CW-1:0] a_col;
    logic [AW-1:0] cell_addr;
    logic          row_adv;
    logic [15:0]   row_ext;
    logic [15:0]   col_ext;

    assign accept  = s_valid && s_ready;
    assign row_inc = {1'b0, cur_row_reg} + 1'b1;
    assign col_inc = {1'b0, cur_col_reg} + 1'b1;

    always_comb begin
        if (s_row_req[15]) begin
            clamp_row = '0;
        end else if (s_row_req >= 16'(ROWS)) begin
            clamp_row = RW'(ROWS - 1);
        end else begin
            clamp_row = RW'(s_row_req);
        end
        if (s_col_req[15]) begin
            clamp_col = '0;
        end else if (s_col_req >= 16'(COLS)) begin
            clamp_col = CW'(COLS - 1);
        end else begin
            clamp_col = CW'(s_col_req);
        end
    end

    // one shared address multiplier: read cell, put char, backspace
    always_comb begin
        if (s_cmd == tce_pkg::CMD_READ_CELL) begin
            a_row = clamp_row;
            a_col = clamp_col;
        end else if (s_ch == tce_pkg::CH_BACKSPACE) begin
            a_row = cur_row_reg;
            a_col = cur_col_reg - 1'b1;
        end else begin
            a_row = cur_row_reg;
            a_col = cur_col_reg;
        end
        cell_addr = AW'(a_row * COLS + a_col);
    end

    always_comb begin
        state_next      = state_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        color_next      = color_reg;
        fill_color_next = fill_color_reg;
        scan_next       = scan_reg;
        fill_next       = fill_reg;
        pend_next       = 1'b0;
        pend_addr_next  = scan_reg - AW'(COLS);
        cell_char_next  = cell_char_reg;
        cell_color_next = cell_color_reg;
        s_ready         = 1'b0;
        res_push        = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = cell_addr;
        ram_wdata       = {color_reg, s_ch};
        ram_raddr       = cell_addr;
        row_adv         = 1'b0;

        case (state_reg)
            tce_pkg::ST_WIPE, tce_pkg::ST_FILL: begin
                if (pend_reg) begin
                    // last copy of the scroll lands first
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg;
                    ram_wdata = ram_rdata;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = fill_reg;
                    ram_wdata = {fill_color_reg, tce_pkg::CH_SPACE};
                    fill_next = fill_reg + 1'b1;
                    if (fill_reg == LAST_ADDR) begin
                        state_next = (state_reg == tce_pkg::ST_WIPE) ? tce_pkg::ST_IDLE
                                                                     : tce_pkg::ST_RESP;
                    end
                end
            end
            tce_pkg::ST_IDLE: begin
                s_ready         = 1'b1;
                if (accept) begin
                    state_next      = tce_pkg::ST_RESP;
                    cell_char_next  = '0;
                    cell_color_next = '0;
                    case (s_cmd)
                        tce_pkg::CMD_PUT_CHAR: begin
                            if (s_ch == tce_pkg::CH_NEWLINE) begin
                                cur_col_next = '0;
                                row_adv      = 1'b1;
                            end else if (s_ch == tce_pkg::CH_BACKSPACE) begin
                                if (cur_col_reg != '0) begin
                                    cur_col_next = cur_col_reg - 1'b1;
                                    ram_we       = 1'b1;
                                    ram_wdata    = {color_reg, tce_pkg::CH_SPACE};
                                end
                            end else begin
                                ram_we = 1'b1;
                                if (col_inc >= (CW+1)'(COLS)) begin
                                    cur_col_next = '0;
                                    row_adv      = 1'b1;
                                end else begin
                                    cur_col_next = col_inc[CW-1:0];
                                end
                            end
                            if (row_adv) begin
                                if (row_inc >= (RW+1)'(ROWS)) begin
                                    cur_row_next    = RW'(ROWS - 1);
                                    fill_color_next = color_reg;
                                    scan_next       = FIRST_SRC;
                                    fill_next       = BOTTOM_ADDR;
                                    state_next      = (ROWS > 1) ? tce_pkg::ST_SCROLL
                                                                 : tce_pkg::ST_FILL;
                                end else begin
                                    cur_row_next = row_inc[RW-1:0];
                                end
                            end
                        end
                        tce_pkg::CMD_SET_CUR: begin
                            cur_row_next = clamp_row;
                            cur_col_next = clamp_col;
                        end
                        tce_pkg::CMD_CLEAR: begin
                            cur_row_next    = '0;
                            cur_col_next    = '0;
                            fill_color_next = color_reg;
                            fill_next       = '0;
                            state_next      = tce_pkg::ST_FILL;
                        end
                        tce_pkg::CMD_SET_COLOR: begin
                            color_next = {s_bg, s_fg};
                        end
                        tce_pkg::CMD_RST_COLOR: begin
                            color_next = tce_pkg::DEFAULT_COLOR;
                        end
                        tce_pkg::CMD_INIT: begin
                            cur_row_next    = '0;
                            cur_col_next    = '0;
                            color_next      = tce_pkg::DEFAULT_COLOR;
                            fill_color_next = tce_pkg::DEFAULT_COLOR;
                            fill_next       = '0;
                            state_next      = tce_pkg::ST_FILL;
                        end
                        tce_pkg::CMD_READ_CELL: begin
                            state_next = tce_pkg::ST_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tce_pkg::ST_READ: begin
                cell_char_next  = ram_rdata[7:0];
                cell_color_next = ram_rdata[15:8];
                state_next      = tce_pkg::ST_RESP;
            end
            tce_pkg::ST_SCROLL: begin
                // read one row down, write it back in the next cycle
                ram_raddr = scan_reg;
                pend_next = 1'b1;
                scan_next = scan_reg + 1'b1;
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg;
                    ram_wdata = ram_rdata;
                end
                if (scan_reg == LAST_ADDR) begin
                    state_next = tce_pkg::ST_FILL;
                end
            end
            tce_pkg::ST_RESP: begin
                if (out_free) begin
                    res_push   = 1'b1;
                    state_next = tce_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tce_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tce_pkg::ST_WIPE;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            color_reg      <= tce_pkg::DEFAULT_COLOR;
            fill_color_reg <= tce_pkg::DEFAULT_COLOR;
            fill_reg       <= '0;
            scan_reg       <= '0;
            pend_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            color_reg      <= color_next;
            fill_color_reg <= fill_color_next;
            fill_reg       <= fill_next;
            scan_reg       <= scan_next;
            pend_reg       <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg  <= pend_addr_next;
        cell_char_reg  <= cell_char_next;
        cell_color_reg <= cell_color_next;
    end

    assign row_ext = 16'(cur_row_reg);
    assign col_ext = 16'(cur_col_reg);

    always_comb begin
        res.cursor_pos = 11'(cur_row_reg * COLS + cur_col_reg);
        res.cursor_row = row_ext[4:0];
        res.cursor_col = col_ext[6:0];
        res.cell_char  = cell_char_reg;
        res.cell_color = cell_color_reg;
    end

    a_pend_after_scroll: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> $past(state_reg == tce_pkg::ST_SCROLL))
        else $error("copy write without a scroll read");

    a_cursor_on_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tce_pkg::ST_IDLE |->
            (32'(cur_row_reg) < ROWS) && (32'(cur_col_reg) < COLS))
        else $error("cursor off screen");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != tce_pkg::ST_IDLE)
        else $error("transaction accepted without processing");

    a_scroll_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tce_pkg::ST_SCROLL && ram_we) |-> ram_waddr != ram_raddr)
        else $error("scroll write hits the cell being read");

endmodule

`default_nettype wire

@@ tb/text_console_checker.sv @@
`default_nettype none

module text_console_checker #(
    parameter int ROWS = tce_pkg::ROWS_DEF,
    parameter int COLS = tce_pkg::COLS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic [2:0]         s_cmd,
    input  wire logic [7:0]         s_ch,
    input  wire logic signed [15:0] s_row_req,
    input  wire logic signed [15:0] s_col_req,
    input  wire logic [3:0]         s_fg,
    input  wire logic [3:0]         s_bg,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic [10:0]        m_cursor_pos,
    input  wire logic [4:0]         m_cursor_row,
    input  wire logic [6:0]         m_cursor_col,
    input  wire logic [7:0]         m_cell_char,
    input  wire logic [7:0]         m_cell_color,
    output int                      fail_count,
    output int                      reports_owed,
    output int                      cursor_row_now,
    output int                      cursor_col_now,
    output int                      reports_checked,
    output int                      scroll_count,
    output int                      cell_reads
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCELLS = ROWS * COLS;

    // shadow of the screen memory: colour in the high byte, character in the low byte
    logic [15:0]    screen [NCELLS];
    int             row_q;
    int             col_q;
    logic [7:0]     color_q;
    tce_pkg::res_t  cursor_reports_q[$];

    function automatic int clamp_to(input logic signed [15:0] v, input int lim);
        if (v < 0) return 0;
        if (int'(v) >= lim) return lim - 1;
        return int'(v);
    endfunction

    task automatic paint_screen(input logic [7:0] color);
        for (int i = 0; i < NCELLS; i++) screen[i] = {color, tce_pkg::CH_SPACE};
    endtask

    task automatic scroll_screen();
        for (int i = 0; i < NCELLS - COLS; i++) screen[i] = screen[i + COLS];
        for (int c = 0; c < COLS; c++)
            screen[(ROWS - 1) * COLS + c] = {color_q, tce_pkg::CH_SPACE};
        row_q = ROWS - 1;
        scroll_count++;
    endtask

    task automatic type_char(input logic [7:0] chr);
        if (chr == tce_pkg::CH_NEWLINE) begin
            col_q = 0;
            row_q++;
        end else if (chr == tce_pkg::CH_BACKSPACE) begin
            // nothing happens at the left margin
            if (col_q > 0) begin
                col_q--;
                screen[row_q * COLS + col_q] = {color_q, tce_pkg::CH_SPACE};
            end
        end else begin
            screen[row_q * COLS + col_q] = {color_q, chr};
            col_q++;
            if (col_q >= COLS) begin
                col_q = 0;
                row_q++;
            end
        end
        if (row_q >= ROWS) scroll_screen();
    endtask

    task automatic console_apply(input logic [2:0] cmd, input logic [7:0] chr,
                                 input logic signed [15:0] row_req,
                                 input logic signed [15:0] col_req,
                                 input logic [3:0] fg, input logic [3:0] bg);
        tce_pkg::res_t rep;
        int            r;
        int            c;
        logic [15:0]   cell_word;
        rep = '0;
        case (cmd)
            tce_pkg::CMD_PUT_CHAR: type_char(chr);
            tce_pkg::CMD_SET_CUR: begin
                row_q = clamp_to(row_req, ROWS);
                col_q = clamp_to(col_req, COLS);
            end
            tce_pkg::CMD_CLEAR: begin
                paint_screen(color_q);
                row_q = 0;
                col_q = 0;
            end
            tce_pkg::CMD_SET_COLOR: color_q = {bg, fg};
            tce_pkg::CMD_RST_COLOR: color_q = tce_pkg::DEFAULT_COLOR;
            tce_pkg::CMD_INIT: begin
                row_q = 0;
                col_q = 0;
                color_q = tce_pkg::DEFAULT_COLOR;
                paint_screen(tce_pkg::DEFAULT_COLOR);
            end
            tce_pkg::CMD_READ_CELL: begin
                r = clamp_to(row_req, ROWS);
                c = clamp_to(col_req, COLS);
                cell_word = screen[r * COLS + c];
                rep.cell_char = cell_word[7:0];
                rep.cell_color = cell_word[15:8];
                cell_reads++;
            end
            default: ;
        endcase
        rep.cursor_pos = 11'(row_q * COLS + col_q);
        rep.cursor_row = 5'(row_q);
        rep.cursor_col = 7'(col_q);
        cursor_reports_q.push_back(rep);
    endtask

    task automatic compare_field(input string name, input logic [10:0] want,
                                 input logic [10:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_report();
        tce_pkg::res_t want;
        if (cursor_reports_q.size() == 0) begin
            $error("result transaction with no command outstanding");
            fail_count++;
            return;
        end
        want = cursor_reports_q.pop_front();
        compare_field("cursor_pos", want.cursor_pos, m_cursor_pos);
        compare_field("cursor_row", 11'(want.cursor_row), 11'(m_cursor_row));
        compare_field("cursor_col", 11'(want.cursor_col), 11'(m_cursor_col));
        compare_field("cell_char", 11'(want.cell_char), 11'(m_cell_char));
        compare_field("cell_color", 11'(want.cell_color), 11'(m_cell_color));
        reports_checked++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            row_q = 0;
            col_q = 0;
            color_q = tce_pkg::DEFAULT_COLOR;
            paint_screen(tce_pkg::DEFAULT_COLOR);
            cursor_reports_q.delete();
        end else begin
            // a result is always for an older command, so check before predicting
            if (m_valid && m_ready) check_report();
            if (s_valid && s_ready)
                console_apply(s_cmd, s_ch, s_row_req, s_col_req, s_fg, s_bg);
        end
        reports_owed = cursor_reports_q.size();
        cursor_row_now = row_q;
        cursor_col_now = col_q;
    end

endmodule

`default_nettype wire

@@ tb/tb_text_console_engine.sv @@
`default_nettype none

module tb_text_console_engine;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam int RANDOM_ITEMS = 1000;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_cmd;
    logic [7:0]         s_ch;
    logic signed [15:0] s_row_req;
    logic signed [15:0] s_col_req;
    logic [3:0]         s_fg;
    logic [3:0]         s_bg;
    logic               m_valid;
    logic               m_ready;
    logic [10:0]        m_cursor_pos;
    logic [4:0]         m_cursor_row;
    logic [6:0]         m_cursor_col;
    logic [7:0]         m_cell_char;
    logic [7:0]         m_cell_color;

    int fail_count;
    int reports_owed;
    int cursor_row_now;
    int cursor_col_now;
    int reports_checked;
    int scroll_count;
    int cell_reads;

    int items_sent;
    bit steady_in;
    bit steady_out;

    text_console_engine u_dut (.*);

    text_console_checker u_checker (.*);

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    initial begin
        #120_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send(input logic [2:0] cmd, input logic [7:0] chr,
                        input logic [15:0] row_req, input logic [15:0] col_req,
                        input logic [3:0] fg, input logic [3:0] bg);
        int gap;
        gap = steady_in ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_cmd = cmd;
        s_ch = chr;
        s_row_req = row_req;
        s_col_req = col_req;
        s_fg = fg;
        s_bg = bg;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic do_put(input logic [7:0] chr);
        send(tce_pkg::CMD_PUT_CHAR, chr, 16'($urandom), 16'($urandom), 4'($urandom),
             4'($urandom));
    endtask

    task automatic do_set_cursor(input logic [15:0] row_req, input logic [15:0] col_req);
        send(tce_pkg::CMD_SET_CUR, 8'($urandom), row_req, col_req, 4'($urandom),
             4'($urandom));
    endtask

    task automatic do_read(input logic [15:0] row_req, input logic [15:0] col_req);
        send(tce_pkg::CMD_READ_CELL, 8'($urandom), row_req, col_req, 4'($urandom),
             4'($urandom));
    endtask

    task automatic do_color(input logic [3:0] fg, input logic [3:0] bg);
        send(tce_pkg::CMD_SET_COLOR, 8'($urandom), 16'($urandom), 16'($urandom), fg, bg);
    endtask

    task automatic do_cmd(input logic [2:0] cmd);
        send(cmd, 8'($urandom), 16'($urandom), 16'($urandom), 4'($urandom), 4'($urandom));
    endtask

    // result side: random stall before each transaction, with stretches of none
    initial begin
        int stall;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 24) == 0) steady_out = !steady_out;
            stall = steady_out ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    initial begin
        int          pick;
        int          run_len;
        int          k;
        int          goal;
        logic [7:0]  chr;
        logic [15:0] row_req;
        logic [15:0] col_req;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cmd = tce_pkg::CMD_PUT_CHAR;
        s_ch = '0;
        s_row_req = '0;
        s_col_req = '0;
        s_fg = '0;
        s_bg = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: reset contents, clamping, odd bytes, backspace, wrap, scroll
        do_read(16'd0, 16'd0);
        do_read(16'h8000, 16'h7FFF);
        do_read(16'h7FFF, 16'hFFFF);
        do_color(4'h0, 4'hF);
        do_put(8'h41);
        do_put(8'hFF);
        do_put(8'h00);
        do_put(8'h80);
        do_put(tce_pkg::CH_BACKSPACE);
        do_read(16'd0, 16'd3);
        do_set_cursor(16'd0, 16'd0);
        do_put(tce_pkg::CH_BACKSPACE);
        do_set_cursor(16'hFFFB, 16'd200);
        do_put(8'h5A);
        do_read(16'd0, 16'd79);
        do_set_cursor(16'd24, 16'd78);
        do_put(8'h78);
        do_put(8'h79);
        do_read(16'd23, 16'd79);
        do_set_cursor(16'd24, 16'd5);
        do_put(tce_pkg::CH_NEWLINE);
        do_color(4'hF, 4'h0);
        do_cmd(tce_pkg::CMD_CLEAR);
        do_read(16'd12, 16'd40);
        do_cmd(tce_pkg::CMD_RST_COLOR);
        do_cmd(CMD_UNUSED);
        do_cmd(tce_pkg::CMD_INIT);
        do_read(16'd24, 16'd79);

        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal) begin
            if ($urandom_range(0, 9) == 0) steady_in = !steady_in;
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                // a run of text, often placed at a row end or on the bottom row
                if ($urandom_range(0, 2) == 0) begin
                    row_req = ($urandom_range(0, 2) == 0)
                              ? 16'(tce_pkg::ROWS_DEF - 1)
                              : 16'($urandom_range(0, tce_pkg::ROWS_DEF - 1));
                    col_req = ($urandom_range(0, 1) == 0)
                              ? 16'(tce_pkg::COLS_DEF - 1 - $urandom_range(0, 3))
                              : 16'($urandom_range(0, tce_pkg::COLS_DEF - 1));
                    do_set_cursor(row_req, col_req);
                end
                run_len = $urandom_range(3, 20);
                repeat (run_len) begin
                    k = $urandom_range(0, 19);
                    chr = (k == 0) ? tce_pkg::CH_NEWLINE
                        : (k == 1) ? tce_pkg::CH_BACKSPACE : 8'($urandom);
                    do_put(chr);
                end
                // read back around the cursor; negative coordinates just clamp
                run_len = $urandom_range(1, 3);
                repeat (run_len)
                    do_read(16'(cursor_row_now - $urandom_range(0, 1)),
                            16'(cursor_col_now - $urandom_range(0, 6)));
            end else if (pick < 70) begin
                if ($urandom_range(0, 3) == 0)
                    do_read(16'($urandom), 16'($urandom));
                else
                    do_read(16'($urandom_range(0, tce_pkg::ROWS_DEF - 1)),
                            16'($urandom_range(0, tce_pkg::COLS_DEF - 1)));
            end else if (pick < 82) begin
                if ($urandom_range(0, 3) == 0)
                    do_cmd(tce_pkg::CMD_RST_COLOR);
                else
                    do_color(4'($urandom), 4'($urandom));
            end else if (pick < 90) begin
                if ($urandom_range(0, 2) == 0)
                    do_set_cursor(16'($urandom), 16'($urandom));
                else
                    do_set_cursor(16'($urandom_range(0, tce_pkg::ROWS_DEF - 1)),
                                  16'($urandom_range(0, tce_pkg::COLS_DEF - 1)));
            end else if (pick < 92) begin
                do_cmd(tce_pkg::CMD_CLEAR);
            end else if (pick < 94) begin
                do_cmd(tce_pkg::CMD_INIT);
            end else if (pick < 96) begin
                do_cmd(CMD_UNUSED);
            end else begin
                // noise: any code, every field random
                send(3'($urandom_range(0, 7)), 8'($urandom), 16'($urandom), 16'($urandom),
                     4'($urandom), 4'($urandom));
            end
        end

        s_valid = 1'b0;
        while (reports_owed != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);

        $display("sent %0d commands, checked %0d results", items_sent, reports_checked);
        $display("covered %0d cell reads and %0d scrolls", cell_reads, scroll_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
